// ===== hw/rtl/bcmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package bcmp_pkg;

   localparam int DIV_STAGES = 32;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TEMP_DIV = 2'd1;
   localparam logic [1:0] ERR_PRES_DIV = 2'd2;

   localparam logic [1:0] CSR_CAL_A = 2'd0;
   localparam logic [1:0] CSR_CAL_B = 2'd1;
   localparam logic [1:0] CSR_CAL_C = 2'd2;
   localparam logic [1:0] CSR_OSS   = 2'd3;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] B4_BIAS     = 32'd32768;
   localparam logic [31:0] B7_SCALE    = 32'd50000;
   localparam logic [31:0] P_COEF_SQ   = 32'd3038;
   localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343;  // minus 7357
   localparam logic [31:0] P_ROUND     = 32'd3791;
   localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
   localparam logic [19:0] PRES_MAX    = 20'hF_FFFF;

   // Data carried alongside a divide through the divider pipeline.
   typedef struct packed {
      logic [1:0]  err;
      logic [15:0] temp;
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        mul2;
   } side_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
      return $unsigned($signed(v) >>> s);
   endfunction

endpackage

// ===== hw/rtl/bcmp_if.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation channels
// Request and response handshake interfaces.
// ----------------------------------------------------------------------------
interface bcmp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temp;
   logic [18:0] raw_pressure;
   modport source (output valid, raw_temp, raw_pressure, input ready);
   modport sink (input valid, raw_temp, raw_pressure, output ready);
endinterface

interface bcmp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temp_decidegree;
   logic [19:0]        pressure_pa;
   logic [1:0]         error_code;
   modport source (output valid, temp_decidegree, pressure_pa, error_code, input ready);
   modport sink (input valid, temp_decidegree, pressure_pa, error_code, output ready);
endinterface

// ===== hw/rtl/bcmp_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring 32 by 32 divide, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module bcmp_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [31:0]         num,
   input  logic [31:0]         den,
   input  bcmp_pkg::side_type  in_side,
   output logic                out_valid,
   output logic [31:0]         quo,
   output bcmp_pkg::side_type  out_side
);
   import bcmp_pkg::*;

   logic     v_ff   [DIV_STAGES];
   logic [31:0] r_ff [DIV_STAGES];
   logic [31:0] n_ff [DIV_STAGES];
   logic [31:0] q_ff [DIV_STAGES];
   logic [31:0] d_ff [DIV_STAGES];
   side_type s_ff   [DIV_STAGES];

   logic     v_in   [DIV_STAGES];
   logic [31:0] r_in [DIV_STAGES];
   logic [31:0] n_in [DIV_STAGES];
   logic [31:0] q_in [DIV_STAGES];
   logic [31:0] d_in [DIV_STAGES];
   side_type s_in   [DIV_STAGES];

   logic [31:0] src_r [DIV_STAGES];
   logic [31:0] src_n [DIV_STAGES];
   logic [31:0] src_q [DIV_STAGES];
   logic [32:0] trial [DIV_STAGES];

   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            v_in[k]  = in_valid;
            src_r[k] = '0;
            src_n[k] = num;
            src_q[k] = '0;
            d_in[k]  = den;
            s_in[k]  = in_side;
         end else begin
            v_in[k]  = v_ff[k-1];
            src_r[k] = r_ff[k-1];
            src_n[k] = n_ff[k-1];
            src_q[k] = q_ff[k-1];
            d_in[k]  = d_ff[k-1];
            s_in[k]  = s_ff[k-1];
         end
         // Partial remainder is below the divisor, so the shifted value fits 33 bits.
         trial[k] = {src_r[k], src_n[k][31]} - {1'b0, d_in[k]};
         if (!trial[k][32]) begin
            r_in[k] = trial[k][31:0];
         end else begin
            r_in[k] = {src_r[k][30:0], src_n[k][31]};
         end
         q_in[k] = {src_q[k][30:0], ~trial[k][32]};
         n_in[k] = {src_n[k][30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_in[k];
         end
         if (adv) begin
            r_ff[k] <= r_in[k];
            n_ff[k] <= n_in[k];
            q_ff[k] <= q_in[k];
            d_ff[k] <= d_in[k];
            s_ff[k] <= s_in[k];
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign quo       = q_ff[DIV_STAGES-1];
   assign out_side  = s_ff[DIV_STAGES-1];

endmodule

// ===== hw/rtl/barometer_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Each request carries a raw temperature and an oversampling-aligned raw
// pressure word; the block returns temperature in tenths of a degree Celsius,
// pressure in pascals and an error code, one response per request, in order.
// A new request is taken in every cycle while no waiting response is held
// back. The pipeline is built from two 32-stage divider pipelines, one for the
// temperature divide and one for the pressure divide, and eleven arithmetic
// stages around them. The whole pipeline advances together and holds when
// the response is not taken. The user writes calibration words through the
// csr port only while no request is in flight; the block does not enforce it.
module barometer_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   bcmp_req_if.sink    req_if,
   bcmp_rsp_if.source  rsp_if
);
   import bcmp_pkg::*;

   // Configuration registers.
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff   <= 2'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAL_A: cal_a_ff <= csr_data;
            CSR_CAL_B: cal_b_ff <= csr_data;
            CSR_CAL_C: cal_c_ff <= csr_data[31:0];
            CSR_OSS:   oss_ff   <= csr_data[1:0];
            default:   cal_a_ff <= cal_a_ff;
         endcase
      end
   end

   // Calibration coefficients as 32-bit words.
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(cal_a_ff[63:48]);
   assign ac2 = sx16(cal_a_ff[47:32]);
   assign ac3 = sx16(cal_a_ff[31:16]);
   assign ac4 = {16'd0, cal_a_ff[15:0]};
   assign ac5 = {16'd0, cal_b_ff[63:48]};
   assign ac6 = {16'd0, cal_b_ff[47:32]};
   assign b1  = sx16(cal_b_ff[31:16]);
   assign b2  = sx16(cal_b_ff[15:0]);
   assign mc  = sx16(cal_c_ff[31:16]);
   assign md  = sx16(cal_c_ff[15:0]);

   // The whole pipeline moves when the output register is empty or taken.
   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // Stage 1: input register.
   logic        v1_ff;
   logic [15:0] ut1_ff;
   logic [18:0] up1_ff;

   // Stage 2: temperature linear term and divide operands.
   logic        v2_ff;
   logic [31:0] x1_2_ff, x1_2_in, dv2_ff, dv2_in, nm2_ff, nm2_in;
   logic [18:0] up2_ff;

   always_comb begin
      x1_2_in = asr32(({16'd0, ut1_ff} - ac6) * ac5, 15);
      dv2_in  = x1_2_in + md;
      nm2_in  = {mc[20:0], 11'd0};
   end

   // Signed divide through sign and magnitude.
   logic        t_na, t_nb;
   logic [31:0] t_ma, t_mb;
   side_type    d1_side_in, d1_side;
   logic        d1_valid;
   logic [31:0] d1_quo;

   always_comb begin
      t_na = nm2_ff[31];
      t_nb = dv2_ff[31];
      t_ma = t_na ? (32'd0 - nm2_ff) : nm2_ff;
      t_mb = t_nb ? (32'd0 - dv2_ff) : dv2_ff;
      d1_side_in      = '0;
      d1_side_in.x1   = x1_2_ff;
      d1_side_in.up   = up2_ff;
      d1_side_in.neg  = t_na ^ t_nb;
      d1_side_in.err  = (dv2_ff == 32'd0) ? ERR_TEMP_DIV : ERR_NONE;
   end

   bcmp_div u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .num       (t_ma),
      .den       (t_mb),
      .in_side   (d1_side_in),
      .out_valid (d1_valid),
      .quo       (d1_quo),
      .out_side  (d1_side)
   );

   // Stage 4: temperature result and B6.
   logic        v4_ff;
   logic [31:0] b6_4_ff, b6_4_in, b5_4, t4;
   logic [15:0] tmp4_ff, tmp4_in;
   logic [1:0]  err4_ff;
   logic [18:0] up4_ff;

   always_comb begin
      b5_4 = d1_side.x1 + (d1_side.neg ? (32'd0 - d1_quo) : d1_quo);
      t4   = asr32(b5_4 + 32'd8, 4);
      if ($signed(t4) > 32'sd32767) begin
         tmp4_in = 16'h7FFF;
      end else if ($signed(t4) < -32'sd32768) begin
         tmp4_in = 16'h8000;
      end else begin
         tmp4_in = t4[15:0];
      end
      b6_4_in = b5_4 - B6_OFFSET;
   end

   // Stage 5: products of B6.
   logic        v5_ff;
   logic [31:0] sqp5_ff, ac2b6_5_ff, ac3b6_5_ff;
   logic [15:0] tmp5_ff;
   logic [1:0]  err5_ff;
   logic [18:0] up5_ff;

   // Stage 6: products of the squared term.
   logic        v6_ff;
   logic [31:0] b2sq6_ff, b1sq6_ff, ac2b6_6_ff, ac3b6_6_ff, sq6;
   logic [15:0] tmp6_ff;
   logic [1:0]  err6_ff;
   logic [18:0] up6_ff;

   assign sq6 = asr32(sqp5_ff, 12);

   // Stage 7: B3 and the B4 factor.
   logic        v7_ff;
   logic [31:0] b3_7_ff, b3_7_in, x3p7_ff, x3p7_in, x3_7, bv7;
   logic [15:0] tmp7_ff;
   logic [1:0]  err7_ff;
   logic [18:0] up7_ff;

   always_comb begin
      x3_7 = asr32(b2sq6_ff, 11) + asr32(ac2b6_6_ff, 11);
      bv7  = (({ac1[29:0], 2'd0} + x3_7) << oss_ff) + 32'd2;
      // Divide by four truncating toward zero.
      b3_7_in = asr32(bv7 + (bv7[31] ? 32'd3 : 32'd0), 2);
      x3p7_in = asr32(asr32(ac3b6_6_ff, 13) + asr32(b1sq6_ff, 16) + 32'd2, 2);
   end

   // Stage 8: B4 and B7.
   logic        v8_ff;
   logic [31:0] b4_8_ff, b4_8_in, b7_8_ff, b7_8_in;
   logic [15:0] tmp8_ff;
   logic [1:0]  err8_ff;

   always_comb begin
      b4_8_in = (ac4 * (x3p7_ff + B4_BIAS)) >> 15;
      b7_8_in = ({13'd0, up7_ff} - b3_7_ff) * (B7_SCALE >> oss_ff);
   end

   side_type    d2_side_in, d2_side;
   logic        d2_valid;
   logic [31:0] d2_quo, d2_num;

   always_comb begin
      d2_side_in      = '0;
      d2_side_in.temp = tmp8_ff;
      d2_side_in.mul2 = (b7_8_ff >= SIGN_BIT);
      d2_num          = d2_side_in.mul2 ? b7_8_ff : {b7_8_ff[30:0], 1'b0};
      if (err8_ff == ERR_NONE && b4_8_ff == 32'd0) begin
         d2_side_in.err = ERR_PRES_DIV;
      end else begin
         d2_side_in.err = err8_ff;
      end
   end

   bcmp_div u_div_pres (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_ff),
      .num       (d2_num),
      .den       (b4_8_ff),
      .in_side   (d2_side_in),
      .out_valid (d2_valid),
      .quo       (d2_quo),
      .out_side  (d2_side)
   );

   // Stage 9: pressure before correction.
   logic        v9_ff;
   logic [31:0] p9_ff, p9_in;
   logic [15:0] tmp9_ff;
   logic [1:0]  err9_ff;

   assign p9_in = d2_side.mul2 ? {d2_quo[30:0], 1'b0} : d2_quo;

   // Stage 10: correction products.
   logic        v10_ff;
   logic [31:0] p10_ff, xsq10_ff, xsq10_in, m2_10_ff, x8_10;
   logic [15:0] tmp10_ff;
   logic [1:0]  err10_ff;

   always_comb begin
      x8_10    = asr32(p9_ff, 8);
      xsq10_in = x8_10 * x8_10;
   end

   // Stage 11: scaled square term.
   logic        v11_ff;
   logic [31:0] p11_ff, m1_11_ff, x2_11_ff;
   logic [15:0] tmp11_ff;
   logic [1:0]  err11_ff;

   // Stage 12: final pressure, saturation and error masking.
   logic [31:0] pf12;
   logic [19:0] pres_in;
   logic [15:0] temp_in;
   logic [15:0] temp_out_ff;
   logic [19:0] pres_out_ff;
   logic [1:0]  err_out_ff;

   always_comb begin
      pf12 = p11_ff + asr32(asr32(m1_11_ff, 16) + x2_11_ff + P_ROUND, 4);
      if (pf12[31]) begin
         pres_in = '0;
      end else if (pf12[30:20] != '0) begin
         pres_in = PRES_MAX;
      end else begin
         pres_in = pf12[19:0];
      end
      temp_in = tmp11_ff;
      if (err11_ff != ERR_NONE) begin
         pres_in = '0;
      end
      if (err11_ff == ERR_TEMP_DIV) begin
         temp_in = '0;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_if.valid;
         v2_ff        <= v1_ff;
         v4_ff        <= d1_valid;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= d2_valid;
         v10_ff       <= v9_ff;
         v11_ff       <= v10_ff;
         rsp_valid_ff <= v11_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         ut1_ff      <= req_if.raw_temp;
         up1_ff      <= req_if.raw_pressure;

         x1_2_ff     <= x1_2_in;
         dv2_ff      <= dv2_in;
         nm2_ff      <= nm2_in;
         up2_ff      <= up1_ff;

         b6_4_ff     <= b6_4_in;
         tmp4_ff     <= tmp4_in;
         err4_ff     <= d1_side.err;
         up4_ff      <= d1_side.up;

         sqp5_ff     <= b6_4_ff * b6_4_ff;
         ac2b6_5_ff  <= ac2 * b6_4_ff;
         ac3b6_5_ff  <= ac3 * b6_4_ff;
         tmp5_ff     <= tmp4_ff;
         err5_ff     <= err4_ff;
         up5_ff      <= up4_ff;

         b2sq6_ff    <= b2 * sq6;
         b1sq6_ff    <= b1 * sq6;
         ac2b6_6_ff  <= ac2b6_5_ff;
         ac3b6_6_ff  <= ac3b6_5_ff;
         tmp6_ff     <= tmp5_ff;
         err6_ff     <= err5_ff;
         up6_ff      <= up5_ff;

         b3_7_ff     <= b3_7_in;
         x3p7_ff     <= x3p7_in;
         tmp7_ff     <= tmp6_ff;
         err7_ff     <= err6_ff;
         up7_ff      <= up6_ff;

         b4_8_ff     <= b4_8_in;
         b7_8_ff     <= b7_8_in;
         tmp8_ff     <= tmp7_ff;
         err8_ff     <= err7_ff;

         p9_ff       <= p9_in;
         tmp9_ff     <= d2_side.temp;
         err9_ff     <= d2_side.err;

         p10_ff      <= p9_ff;
         xsq10_ff    <= xsq10_in;
         m2_10_ff    <= P_COEF_LIN * p9_ff;
         tmp10_ff    <= tmp9_ff;
         err10_ff    <= err9_ff;

         p11_ff      <= p10_ff;
         m1_11_ff    <= xsq10_ff * P_COEF_SQ;
         x2_11_ff    <= asr32(m2_10_ff, 16);
         tmp11_ff    <= tmp10_ff;
         err11_ff    <= err10_ff;

         temp_out_ff <= temp_in;
         pres_out_ff <= pres_in;
         err_out_ff  <= err11_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.temp_decidegree = temp_out_ff;
   assign rsp_if.pressure_pa     = pres_out_ff;
   assign rsp_if.error_code      = err_out_ff;

endmodule

// ===== bench/bcmp_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer compensation bench channels
// Note: the block's own channel interfaces live with the RTL; this file holds
// the bench-side request and expected-response records used by the bench queues.
// ----------------------------------------------------------------------------
package bcmp_tb_pkg;
   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_pressure;
   } meas_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic [19:0]        pres;
      logic [1:0]         err;
   } comp_type;
endpackage

// ===== bench/tb_barometer_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Drives raw temperature and pressure requests through the compensation
// block under several calibration sets and oversampling settings, computes
// the expected compensated values alongside, and checks every response in
// order while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_barometer_compensation;
   import bcmp_pkg::*;
   import bcmp_tb_pkg::*;

   localparam int LATENCY   = 75;
   localparam int CYCLE_CAP = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_CAL_A;
   logic [63:0] csr_data = '0;

   bcmp_req_if req_if ();
   bcmp_rsp_if rsp_if ();

   barometer_compensation u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bench copy of the calibration registers.
   logic [63:0] cal_a = '0, cal_b = '0;
   logic [31:0] cal_c = '0;
   logic [1:0]  oss_cfg = 2'd1;

   meas_type pending_meas[$];
   comp_type expected_comp[$];

   int errors = 0;
   int cycles = 0;
   int sent = 0;
   int checked = 0;
   int err_seen[3] = '{0, 0, 0};
   bit tx_quiet = 1'b0;   // no random gaps on the request side
   bit rx_quiet = 1'b0;   // no random stalls on the response side
   int rx_hold = 0;       // long response-side hold-off, in cycles
   bit req_fire = 1'b0;   // request taken at the last rising edge

   function automatic logic [31:0] mul_lo(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] sra(logic [31:0] v, int s);
      return $unsigned($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] ext16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Truncating signed divide; the most negative value over -1 wraps.
   function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // Compensation of one raw pair under the current calibration.
   function automatic comp_type compensate(meas_type m);
      comp_type r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv;
      int signed t;
      int signed ps;
      ac1 = ext16(cal_a[63:48]); ac2 = ext16(cal_a[47:32]);
      ac3 = ext16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
      ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
      b1 = ext16(cal_b[31:16]); b2 = ext16(cal_b[15:0]);
      mc = ext16(cal_c[31:16]); md = ext16(cal_c[15:0]);
      r = '0;
      x1 = sra(mul_lo({16'd0, m.raw_temp} - ac6, ac5), 15);
      dv = x1 + md;
      if (dv == 0) begin
         r.err = ERR_TEMP_DIV;
         return r;
      end
      x2 = div_trunc(mc << 11, dv);
      b5 = x1 + x2;
      t = $signed(sra(b5 + 32'd8, 4));
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      r.temp = t[15:0];
      b6 = b5 - 32'd4000;
      sq = sra(mul_lo(b6, b6), 12);
      x1 = sra(mul_lo(b2, sq), 11);
      x2 = sra(mul_lo(ac2, b6), 11);
      x3 = x1 + x2;
      b3 = div_trunc(((mul_lo(ac1, 32'd4) + x3) << oss_cfg) + 32'd2, 32'd4);
      x1 = sra(mul_lo(ac3, b6), 13);
      x2 = sra(mul_lo(b1, sq), 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = mul_lo(ac4, x3 + 32'd32768) >> 15;
      if (b4 == 0) begin
         r.err = ERR_PRES_DIV;
         return r;
      end
      b7 = mul_lo({13'd0, m.raw_pressure} - b3, 32'd50000 >> oss_cfg);
      if (!b7[31]) p = mul_lo(b7, 32'd2) / b4;
      else p = mul_lo(b7 / b4, 32'd2);
      x1 = sra(p, 8);
      x1 = mul_lo(x1, x1);
      x1 = sra(mul_lo(x1, 32'd3038), 16);
      x2 = sra(mul_lo(-32'd7357, p), 16);
      p = p + sra(x1 + x2 + 32'd3791, 4);
      ps = $signed(p);
      if (ps < 0) ps = 0;
      if (ps > 1048575) ps = 1048575;
      r.pres = ps[19:0];
      r.err = ERR_NONE;
      return r;
   endfunction

   // Request handshake, seen at the rising edge. The expectation is computed
   // when the request is taken.
   always @(posedge clock) begin
      req_fire = !reset && req_if.valid && req_if.ready;
      if (req_fire) begin
         expected_comp.push_back(compensate({req_if.raw_temp, req_if.raw_pressure}));
         void'(pending_meas.pop_front());
         sent++;
      end
   end

   // Request driver: changes on the falling edge, and holds a request that
   // has not been taken yet.
   initial begin
      req_if.valid = 1'b0;
      req_if.raw_temp = '0;
      req_if.raw_pressure = '0;
   end

   always @(negedge clock) begin
      if (!reset && (req_fire || !req_if.valid)) begin
         if (pending_meas.size() > 0 && (tx_quiet || $urandom_range(99) >= 10)) begin
            req_if.valid <= 1'b1;
            req_if.raw_temp <= pending_meas[0].raw_temp;
            req_if.raw_pressure <= pending_meas[0].raw_pressure;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls, plus a long hold-off when requested.
   initial rsp_if.ready = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= rx_quiet || ($urandom_range(99) >= 10);
      end
   end

   // Response monitor: sampled at the rising edge, compared field by field.
   always @(posedge clock) begin
      comp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_comp.size() == 0) begin
            $display("%0t: response with nothing expected: temp %0d pres %0d err %0d",
                     $time, rsp_if.temp_decidegree, rsp_if.pressure_pa, rsp_if.error_code);
            errors++;
         end else begin
            want = expected_comp.pop_front();
            checked++;
            if (want.err <= 2) err_seen[want.err]++;
            if (rsp_if.temp_decidegree !== want.temp) begin
               $display("%0t: temperature expected %0d got %0d",
                        $time, want.temp, rsp_if.temp_decidegree);
               errors++;
            end
            if (rsp_if.pressure_pa !== want.pres) begin
               $display("%0t: pressure expected %0d got %0d",
                        $time, want.pres, rsp_if.pressure_pa);
               errors++;
            end
            if (rsp_if.error_code !== want.err) begin
               $display("%0t: error code expected %0d got %0d",
                        $time, want.err, rsp_if.error_code);
               errors++;
            end
         end
      end
   end

   // Watchdog on the total cycle count.
   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Writes one calibration register on the falling edge, for one cycle.
   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CAL_A: cal_a = val;
         CSR_CAL_B: cal_b = val;
         CSR_CAL_C: cal_c = val[31:0];
         CSR_OSS:   oss_cfg = val[1:0];
         default: ;
      endcase
   endtask

   // Waits until every expected response has come back and the pipe is empty.
   task automatic drain();
      while (pending_meas.size() > 0 || req_if.valid || expected_comp.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic queue_meas(logic [15:0] ut, logic [18:0] up);
      pending_meas.push_back('{raw_temp: ut, raw_pressure: up});
   endtask

   // A realistic calibration set with small random perturbations, so that
   // most requests land in the ordinary, error-free path.
   task automatic load_typical(logic [1:0] oss);
      logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      ac1 = 16'(16'd408 + $urandom_range(200) - 100);
      ac2 = 16'(-16'sd72 + $urandom_range(40) - 20);
      ac3 = 16'(-16'sd14383 + $urandom_range(2000) - 1000);
      ac4 = 16'(16'd32741 + $urandom_range(2000) - 1000);
      ac5 = 16'(16'd32757 + $urandom_range(2000) - 1000);
      ac6 = 16'(16'd23153 + $urandom_range(2000) - 1000);
      b1  = 16'(16'd6190 + $urandom_range(200) - 100);
      b2  = 16'(16'd4 + $urandom_range(8));
      mc  = 16'(-16'sd8711 + $urandom_range(400) - 200);
      md  = 16'(16'd2868 + $urandom_range(400) - 200);
      write_reg(CSR_CAL_A, {ac1, ac2, ac3, ac4});
      write_reg(CSR_CAL_B, {ac5, ac6, b1, b2});
      write_reg(CSR_CAL_C, {32'($urandom), mc, md});
      write_reg(CSR_OSS, {62'($urandom), oss});
   endtask

   task automatic load_random();
      write_reg(CSR_CAL_A, {$urandom, $urandom});
      write_reg(CSR_CAL_B, {$urandom, $urandom});
      write_reg(CSR_CAL_C, {$urandom, $urandom});
      write_reg(CSR_OSS, {$urandom, $urandom});
   endtask

   initial begin
      int phase;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset calibration (all zero) makes the temperature divisor
      // zero for any raw temperature.
      queue_meas(16'd0, 19'd0);
      queue_meas(16'hFFFF, 19'h7FFFF);
      drain();

      // Directed: typical calibration at each oversampling setting, with raw
      // field extremes and datasheet-like values.
      for (int o = 0; o < 4; o++) begin
         load_typical(o[1:0]);
         queue_meas(16'd27898, 19'(23843 << o));
         queue_meas(16'd0, 19'd0);
         queue_meas(16'hFFFF, 19'h7FFFF);
         queue_meas(16'h5555, 19'h2AAAA);
         queue_meas(16'hAAAA, 19'h55555);
         drain();
      end

      // Directed: pressure divisor zero, with AC4 cleared.
      write_reg(CSR_CAL_A, {cal_a[63:16], 16'd0});
      queue_meas(16'd27898, 19'd23843);
      drain();

      // Directed: temperature divisor zero with a nonzero calibration. With
      // AC5 zero, X1 is zero, so MD zero makes the divisor vanish.
      write_reg(CSR_CAL_B, {16'd0, cal_b[47:0]});
      write_reg(CSR_CAL_C, {cal_c[31:16], 16'd0});
      queue_meas(16'd1234, 19'd4321);
      drain();

      // Directed: most negative MC over minus one in the temperature divide.
      // MC = -32768 gives 0xFC000000 after the shift, not the most negative
      // word, and MD = -1 with X1 zero gives divisor -1.
      write_reg(CSR_CAL_C, {16'h8000, 16'hFFFF});
      queue_meas(16'd0, 19'd100);
      drain();

      // Random phases. Most use realistic calibration; a few are fully random.
      for (phase = 0; phase < 10; phase++) begin
         if (phase % 4 == 3) load_random();
         else load_typical(phase == 0 ? 2'd0 : (phase == 1 ? 2'd3 : 2'($urandom)));
         tx_quiet = (phase == 2);
         rx_quiet = (phase == 2);
         if (phase == 5) begin
            // Long receiver hold-off while requests keep coming, so the
            // pipeline fills and back-pressures the request side.
            rx_hold = 300;
            tx_quiet = 1'b1;
         end
         for (int i = 0; i < 108; i++) begin
            if ($urandom_range(9) < 7)
               queue_meas(16'd20000 + 16'($urandom_range(15000)),
                          19'($urandom_range(20000, 45000) << oss_cfg));
            else
               queue_meas(16'($urandom), 19'($urandom));
         end
         // The request side pauses here until every response has returned.
         drain();
      end

      $display("Sent %0d requests and checked %0d responses over several calibration sets.",
               sent, checked);
      $display("Outcomes: %0d ok, %0d temperature divisor zero, %0d pressure divisor zero.",
               err_seen[0], err_seen[1], err_seen[2]);
      if (errors == 0 && expected_comp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
